>>> src/dpf_pkg.sv
// Package: types and constants shared by the duplicate packet filter modules.
package dpf_pkg;

  localparam int LEN_W   = 16;
  localparam int TIME_W  = 63;
  localparam int CNT_W   = 32;
  localparam int VRD_W   = 2;
  localparam int IN_DW   = 288;
  localparam int IN_UW   = 2;
  localparam int OUT_DW  = 224;
  localparam int OUT_UW  = 2;

  localparam logic [VRD_W-1:0] VRD_DROP    = 2'd0;
  localparam logic [VRD_W-1:0] VRD_REFUSED = 2'd1;
  localparam logic [VRD_W-1:0] VRD_DUP     = 2'd2;
  localparam logic [VRD_W-1:0] VRD_DELIVER = 2'd3;

  typedef struct packed {
    logic [63:0] guid_high;
    logic [63:0] guid_low;
    logic [47:0] source;
    logic [31:0] group_fragment;
  } key_t;

  typedef struct packed {
    logic              vld;
    key_t              key;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic              vld;
    key_t              key;
    logic              hit;
    logic [TIME_W-1:0] hit_time;
  } query_t;

endpackage

>>> src/dpf_cell.sv
// One cache cell: holds one stored key and compares the passing query against it.
module dpf_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  dpf_pkg::query_t q_up,
  output dpf_pkg::query_t q_down,
  input  logic            ins,
  input  dpf_pkg::entry_t ent_in,
  output dpf_pkg::entry_t ent_out
);
  import dpf_pkg::*;

  query_t q_r;
  query_t q_nxt;
  entry_t ent_r;
  logic   match;

  assign match = q_up.vld && ent_r.vld && (q_up.key == ent_r.key);

  always_comb begin
    q_nxt = q_up;
    if (match && !q_up.hit) begin
      q_nxt.hit      = 1'b1;
      q_nxt.hit_time = ent_r.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else if (ins) begin
      ent_r <= ent_in;
    end
  end

  assign q_down  = q_r;
  assign ent_out = ent_r;

endmodule

>>> src/duplicate_packet_filter.sv
// Top level: duplicate packet filter with a shifting chain of key cache cells.
//
// Input channel in_*: one transaction per received packet header. in_tdata holds
// length, guid_high, guid_low, src_host, src_port, group_id, fragment_id, now;
// in_tuser holds rx_error and accepted. Output channel out_*: one transaction per
// input, verdict in out_tuser, delay and running counters in out_tdata.
// cfg_wr_en/cfg_wr_data write min_length; write it only while idle.
// Packets with a receive error or shorter than min_length, and refused packets,
// skip the chain; their result is registered when the finish step commits, and
// the input is freed at the same time. Otherwise the key goes down the chain of
// CACHE_DEPTH cells, one cell per cycle; the result is registered once the key
// has left the last cell and the finish step commits, and the next packet is
// taken then. One item is worked on at a time, the chain walk sets the rate.
// A miss shifts the new key into the first cell, the oldest out of the last one.
// Reset clears the counters, the cell valid bits and min_length; in_tready is
// low while reset is held.
// When out_tready is low the result is held in the output register. The next
// item is still accepted and worked on, then waits in its final step, with
// in_tready low, until the output register is free or being taken.
module duplicate_packet_filter #(
  parameter int CACHE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [dpf_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // length, guid_high, guid_low, src_host, src_port, group_id, fragment_id, now, pad
  input  logic [dpf_pkg::IN_DW-1:0] in_tdata,
  // rx_error, accepted
  input  logic [dpf_pkg::IN_UW-1:0] in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // dup_delay, received_count, received_bytes, duplicate_count, delay_total, pad
  output logic [dpf_pkg::OUT_DW-1:0] out_tdata,
  // verdict
  output logic [dpf_pkg::OUT_UW-1:0] out_tuser
);
  import dpf_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [LEN_W-1:0]  min_len_r;
  key_t              key_r;
  logic [TIME_W-1:0] now_r;
  logic [LEN_W-1:0]  len_r;
  logic [VRD_W-1:0]  vrd_r, vrd_nxt;
  logic [TIME_W-1:0] dly_r, dly_nxt;
  logic [CNT_W-1:0]  pkt_cnt_r, pkt_cnt_nxt;
  logic [CNT_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [CNT_W-1:0]  dup_cnt_r, dup_cnt_nxt;
  logic [TIME_W-1:0] dly_sum_r, dly_sum_nxt;
  logic              out_vld_r;
  logic [OUT_DW-1:0] out_data_r;
  logic [OUT_UW-1:0] out_user_r;

  logic              in_acc;
  logic              commit;
  logic              ins;
  logic              do_search;
  key_t              in_key;
  logic [LEN_W-1:0]  in_len;
  logic [TIME_W-1:0] in_now;
  query_t            q_link [0:CACHE_DEPTH];
  entry_t            ent_link [0:CACHE_DEPTH];
  query_t            q_tail;

  assign in_len   = in_tdata[15:0];
  assign in_key   = '{guid_high: in_tdata[79:16], guid_low: in_tdata[143:80],
                      source: in_tdata[191:144], group_fragment: in_tdata[223:192]};
  assign in_now   = in_tdata[286:224];

  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign do_search = in_acc && !in_tuser[0] && (in_len >= min_len_r) && in_tuser[1];
  assign commit    = (state_r == ST_FINISH) && (!out_vld_r || out_tready);
  assign ins       = commit && (vrd_r == VRD_DELIVER);
  assign q_tail    = q_link[CACHE_DEPTH];

  assign q_link[0]   = '{vld: do_search, key: in_key, hit: 1'b0, hit_time: '0};
  assign ent_link[0] = '{vld: 1'b1, key: key_r, stamp: now_r};

  for (genvar gi = 0; gi < CACHE_DEPTH; gi++) begin : g_cell
    dpf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .q_up    (q_link[gi]),
      .q_down  (q_link[gi+1]),
      .ins     (ins),
      .ent_in  (ent_link[gi]),
      .ent_out (ent_link[gi+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    vrd_nxt   = vrd_r;
    dly_nxt   = dly_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dly_nxt = '0;
          if (in_tuser[0] || (in_len < min_len_r)) begin
            vrd_nxt   = VRD_DROP;
            state_nxt = ST_FINISH;
          end else if (!in_tuser[1]) begin
            vrd_nxt   = VRD_REFUSED;
            state_nxt = ST_FINISH;
          end else begin
            vrd_nxt   = VRD_DELIVER;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (q_tail.vld) begin
          state_nxt = ST_FINISH;
          if (q_tail.hit) begin
            vrd_nxt = VRD_DUP;
            dly_nxt = (now_r >= q_tail.hit_time) ? (now_r - q_tail.hit_time) : '0;
          end
        end
      end
      ST_FINISH: begin
        if (commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pkt_cnt_nxt  = pkt_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    dup_cnt_nxt  = dup_cnt_r;
    dly_sum_nxt  = dly_sum_r;
    if (vrd_r == VRD_DUP || vrd_r == VRD_DELIVER) begin
      pkt_cnt_nxt  = pkt_cnt_r + 1'b1;
      byte_cnt_nxt = byte_cnt_r + {{(CNT_W-LEN_W){1'b0}}, len_r};
    end
    if (vrd_r == VRD_DUP) begin
      dup_cnt_nxt = dup_cnt_r + 1'b1;
      dly_sum_nxt = dly_sum_r + dly_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      min_len_r  <= '0;
      pkt_cnt_r  <= '0;
      byte_cnt_r <= '0;
      dup_cnt_r  <= '0;
      dly_sum_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) min_len_r <= cfg_wr_data;
      if (commit) begin
        pkt_cnt_r  <= pkt_cnt_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        dup_cnt_r  <= dup_cnt_nxt;
        dly_sum_r  <= dly_sum_nxt;
        out_vld_r  <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    vrd_r <= vrd_nxt;
    dly_r <= dly_nxt;
    if (in_acc) begin
      key_r <= in_key;
      now_r <= in_now;
      len_r <= in_len;
    end
    if (commit) begin
      out_user_r <= vrd_r;
      out_data_r <= {2'b0, dly_sum_nxt, dup_cnt_nxt, byte_cnt_nxt, pkt_cnt_nxt, dly_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    q_tail.vld |-> (state_r == ST_SEARCH))
    else $error("query left the chain outside of a search");

  a_ins_no_flight: assert property (@(posedge clk) disable iff (!rst_n)
    ins |-> (state_r == ST_FINISH) && !q_link[1].vld)
    else $error("cache shift while a query is in the chain");

  a_search_follows: assert property (@(posedge clk) disable iff (!rst_n)
    do_search |=> (state_r == ST_SEARCH) && q_link[1].vld)
    else $error("accepted packet did not enter the chain");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_FINISH))
    else $error("result appeared without a finish step");

  a_last_cell_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    ent_link[CACHE_DEPTH].vld |-> ent_link[1].vld)
    else $error("last cell valid while first cell empty");

endmodule
